// File: sv/gbn_pkg.sv
// shared types and constants of the go-back-n sender window
package gbn_pkg;

	// default build sizes
	localparam int unsigned BUFFER_DEPTH_DEF = 64;
	localparam int unsigned SEQ_BITS_DEF     = 16;
	localparam int unsigned WORD_BITS_DEF    = 32;

	// register reset values
	localparam logic [6:0]  WINDOW_RESET  = 7'd8;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// event codes of an input item
	typedef enum logic [1:0] {
		FUNC_ENQ  = 2'd0,
		FUNC_SEND = 2'd1,
		FUNC_ACK  = 2'd2,
		FUNC_TICK = 2'd3
	} func_t;

	// result codes
	typedef enum logic [2:0] {
		KIND_IDLE     = 3'd0,
		KIND_TX       = 3'd1,
		KIND_ENQUEUED = 3'd2,
		KIND_FULL     = 3'd3,
		KIND_ACK      = 3'd4,
		KIND_IGNORED  = 3'd5,
		KIND_REWIND   = 3'd6
	} kind_t;

	// configuration register indexes
	typedef enum logic {
		REG_WINDOW  = 1'b0,
		REG_TIMEOUT = 1'b1
	} reg_idx_t;

	// input item
	typedef struct packed {
		func_t       func;
		logic [31:0] packet_word;
		logic [15:0] ack_number;
	} in_item_t;

	// result item
	typedef struct packed {
		kind_t       result_kind;
		logic [15:0] seq_number;
		logic [31:0] packet_out;
		logic [6:0]  outstanding;
		logic        window_blocked;
	} out_item_t;

	// result of one event, without the buffered word
	typedef struct packed {
		kind_t       kind;
		logic [15:0] seq;
		logic [6:0]  outstanding;
		logic        blocked;
		logic        is_tx;
	} res_t;

endpackage

// File: sv/gbn_ram.sv
// generic single-port-write, registered-read memory
module gbn_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/gbn_core.sv
// window state registers and the per-event update logic
module gbn_core
	import gbn_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned SEQ_BITS     = SEQ_BITS_DEF,
	parameter int unsigned WORD_BITS    = WORD_BITS_DEF,
	parameter int unsigned AW           = $clog2(BUFFER_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  in_item_t             item,
	input  logic [6:0]           window_size,
	input  logic [15:0]          timeout_ticks,
	output res_t                 res,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr
);

	localparam longint unsigned SEQ_MAX = (64'd1 << SEQ_BITS) - 64'd1;
	localparam longint unsigned CAP_L   =
		(longint'(BUFFER_DEPTH) > SEQ_MAX) ? SEQ_MAX : longint'(BUFFER_DEPTH);
	localparam logic [SEQ_BITS-1:0] CAP      = SEQ_BITS'(CAP_L);
	localparam logic [AW-1:0]       LAST     = AW'(BUFFER_DEPTH - 1);
	localparam logic [AW:0]         DEPTH_W  = (AW+1)'(BUFFER_DEPTH);

	logic [SEQ_BITS-1:0] base_q, next_q, tail_q;
	logic [AW-1:0]       base_slot_q, next_slot_q, tail_slot_q;
	logic [15:0]         tcount_q;
	logic                trun_q;

	logic [SEQ_BITS-1:0] base_n, next_n, tail_n;
	logic [AW-1:0]       base_slot_n, next_slot_n, tail_slot_n;
	logic [15:0]         tcount_n;
	logic                trun_n;

	logic [SEQ_BITS-1:0] win_eff, outst, queued, ack_dist, ack, ack_inc, outst_n, seq;
	logic [AW:0]         slot_sum;
	logic [15:0]         limit, tcount_inc;
	kind_t               kind;

	// effective window: zero acts as one, capped at capacity
	always_comb begin
		win_eff = SEQ_BITS'(window_size);
		if (window_size == 7'd0) begin
			win_eff = SEQ_BITS'(1);
		end else if (win_eff > CAP) begin
			win_eff = CAP;
		end
	end

	assign limit      = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
	assign tcount_inc = tcount_q + 16'd1;
	assign ack        = SEQ_BITS'(item.ack_number);
	assign ack_inc    = ack + SEQ_BITS'(1);
	assign outst      = next_q - base_q;
	assign queued     = tail_q - base_q;
	assign ack_dist   = ack - base_q;
	assign slot_sum   = {1'b0, base_slot_q} + (AW+1)'(ack_dist) + (AW+1)'(1);

	// next state and result of the event
	always_comb begin
		base_n      = base_q;
		next_n      = next_q;
		tail_n      = tail_q;
		base_slot_n = base_slot_q;
		next_slot_n = next_slot_q;
		tail_slot_n = tail_slot_q;
		tcount_n    = tcount_q;
		trun_n      = trun_q;
		kind        = KIND_IDLE;
		seq         = base_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		case (item.func)
			FUNC_ENQ: begin
				if (queued >= CAP) begin
					kind = KIND_FULL;
				end else begin
					ram_we      = 1'b1;
					seq         = tail_q;
					tail_n      = tail_q + SEQ_BITS'(1);
					tail_slot_n = (tail_slot_q == LAST) ? '0 : tail_slot_q + AW'(1);
					kind        = KIND_ENQUEUED;
				end
			end
			FUNC_SEND: begin
				if (next_q != tail_q && outst < win_eff) begin
					ram_re = 1'b1;
					seq    = next_q;
					if (next_q == base_q) begin
						trun_n   = 1'b1;
						tcount_n = '0;
					end
					next_n      = next_q + SEQ_BITS'(1);
					next_slot_n = (next_slot_q == LAST) ? '0 : next_slot_q + AW'(1);
					kind        = KIND_TX;
				end
			end
			FUNC_ACK: begin
				if (ack_dist < outst) begin
					base_slot_n = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W)
					                                    : AW'(slot_sum);
					base_n   = ack_inc;
					tcount_n = '0;
					trun_n   = (ack_inc != next_q);
					kind     = KIND_ACK;
					seq      = ack_inc;
				end else begin
					kind = KIND_IGNORED;
				end
			end
			FUNC_TICK: begin
				if (trun_q) begin
					tcount_n = tcount_inc;
					if (tcount_inc >= limit) begin
						next_n      = base_q;
						next_slot_n = base_slot_q;
						trun_n      = 1'b0;
						tcount_n    = '0;
						kind        = KIND_REWIND;
					end
				end
			end
			default: begin
				kind = KIND_IDLE;
			end
		endcase
	end

	assign outst_n   = next_n - base_n;
	assign ram_waddr = tail_slot_q;
	assign ram_wdata = WORD_BITS'(item.packet_word);
	assign ram_raddr = next_slot_q;

	// result fields
	always_comb begin
		res.kind        = kind;
		res.seq         = 16'(seq);
		res.outstanding = 7'(outst_n);
		res.blocked     = (next_n == tail_n) || (outst_n >= win_eff);
		res.is_tx       = (kind == KIND_TX);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			tail_q      <= '0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			tail_slot_q <= '0;
			tcount_q    <= '0;
			trun_q      <= 1'b0;
		end else if (fire) begin
			base_q      <= base_n;
			next_q      <= next_n;
			tail_q      <= tail_n;
			base_slot_q <= base_slot_n;
			next_slot_q <= next_slot_n;
			tail_slot_q <= tail_slot_n;
			tcount_q    <= tcount_n;
			trun_q      <= trun_n;
		end
	end

endmodule

// File: sv/go_back_n_sender_window.sv
// go-back-n sender window: top level with input and result registers
//
// Input channel in_valid/in_stall/in_item carries one event per item:
// enqueue a packet word, a send slot, a cumulative ack, or a timer tick.
// Output channel out_valid/out_stall/out_item gives exactly one result
// item per event, in order. An item is taken on a rising edge with valid
// high and stall low.
// Path: an accepted item is held in the input register, processed
// there by the window logic when it fires, and its result is held in
// the result register until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall;
// the window state and packet buffer port update once per processed item,
// and the buffer's registered read delivers the sent word with the result.
// When the receiver stalls, the result register holds and the input
// register may still take one more item; in_stall rises once both are full.
// The user writes configuration (cfg_we, cfg_index, cfg_data) only while idle; the block does not enforce it.
// Reset clears the window to empty, stops the timer, and loads window 8
// and timeout 1000; buffer contents stay undefined until enqueued.
module go_back_n_sender_window
	import gbn_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned SEQ_BITS     = SEQ_BITS_DEF,
	parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	logic [6:0]           window_q;
	logic [15:0]          timeout_q;
	logic                 valid_s1, valid_s2;
	in_item_t             item_s1;
	res_t                 res, res_s2;
	logic                 fire, accept;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW:  window_q  <= cfg_data[6:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				default:     window_q  <= window_q;
			endcase
		end
	end

	// handshake control
	assign fire     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// window state and event logic
	gbn_core #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.SEQ_BITS     (SEQ_BITS),
		.WORD_BITS    (WORD_BITS),
		.AW           (AW)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.window_size   (window_q),
		.timeout_ticks (timeout_q),
		.res           (res),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr)
	);

	// packet buffer
	gbn_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_buf (
		.clk   (clk),
		.we    (fire && ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (fire && ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	// result item
	always_comb begin
		out_item.result_kind    = res_s2.kind;
		out_item.seq_number     = res_s2.seq;
		out_item.packet_out     = res_s2.is_tx ? 32'(ram_rdata) : 32'd0;
		out_item.outstanding    = res_s2.outstanding;
		out_item.window_blocked = res_s2.blocked;
	end

	assign out_valid = valid_s2;

endmodule

// File: tb/sv/gbn_window_checker.sv
// checker for the go-back-n sender window: predicts every result and compares it
module gbn_window_checker
	import gbn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	input  logic        cfg_we,
	input  reg_idx_t    cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          waiting,
	output logic [15:0] base_now,
	output logic [15:0] next_now
);
	timeunit 1ns;
	timeprecision 1ps;

	// packets that may be queued at once: buffer depth, bounded by the sequence space
	localparam int unsigned QUEUE_CAP =
		(BUFFER_DEPTH_DEF < (1 << SEQ_BITS_DEF) - 1) ? BUFFER_DEPTH_DEF
		                                             : (1 << SEQ_BITS_DEF) - 1;
	localparam int MAX_PRINTED = 200;
	localparam int SLOT_BITS = $clog2(BUFFER_DEPTH_DEF);

	// predicted sender state and register copies
	logic [31:0] word_store [BUFFER_DEPTH_DEF];
	logic [15:0] base_seq;
	logic [15:0] next_seq;
	logic [15:0] tail_seq;
	logic [15:0] tick_count;
	logic        timer_on;
	int unsigned base_slot;
	logic [6:0]  win_reg;
	logic [15:0] timeout_reg;

	out_item_t event_result_q [$];
	out_item_t want;
	out_item_t fresh;
	int        mismatch_count = 0;

	assign errors = mismatch_count;

	function automatic logic [15:0] dist16(input logic [15:0] a, input logic [15:0] b);
		return a - b;
	endfunction

	function automatic logic [SLOT_BITS-1:0] slot_of(input logic [15:0] seq);
		return SLOT_BITS'((base_slot + 32'(dist16(seq, base_seq))) % BUFFER_DEPTH_DEF);
	endfunction

	// zero window acts as one, oversized window as the buffer capacity
	function automatic int unsigned eff_window();
		int unsigned w;
		w = 32'(win_reg);
		if (w == 0) begin
			w = 1;
		end
		if (w > QUEUE_CAP) begin
			w = QUEUE_CAP;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (mismatch_count < MAX_PRINTED) begin
			$display("mismatch at %0t: %s expected %0h got %0h", $realtime, what,
				exp_val, got_val);
		end
		mismatch_count++;
	endtask

	// advance the sender state by one event and work out its result item
	task automatic predict_window_event(input in_item_t it, output out_item_t res);
		int unsigned win;
		int unsigned inflight;
		int unsigned queued;
		int unsigned ack_dist;
		int unsigned limit;
		kind_t       kind;
		logic [15:0] seq;
		logic [31:0] word;
		win = eff_window();
		inflight = 32'(dist16(next_seq, base_seq));
		queued = 32'(dist16(tail_seq, base_seq));
		kind = KIND_IDLE;
		seq = base_seq;
		word = '0;
		case (it.func)
			FUNC_ENQ: begin
				if (queued >= QUEUE_CAP) begin
					kind = KIND_FULL;
				end else begin
					word_store[slot_of(tail_seq)] = it.packet_word;
					seq = tail_seq;
					tail_seq = tail_seq + 16'd1;
					kind = KIND_ENQUEUED;
				end
			end
			FUNC_SEND: begin
				if (next_seq != tail_seq && inflight < win) begin
					seq = next_seq;
					word = word_store[slot_of(next_seq)];
					// sending the base packet (re)starts the retransmit timer
					if (next_seq == base_seq) begin
						timer_on = 1'b1;
						tick_count = '0;
					end
					next_seq = next_seq + 16'd1;
					kind = KIND_TX;
				end
			end
			FUNC_ACK: begin
				ack_dist = 32'(dist16(it.ack_number, base_seq));
				// only an ack of an outstanding packet moves base
				if (ack_dist < inflight) begin
					base_slot = (base_slot + ack_dist + 1) % BUFFER_DEPTH_DEF;
					base_seq = it.ack_number + 16'd1;
					tick_count = '0;
					timer_on = (base_seq != next_seq);
					kind = KIND_ACK;
				end else begin
					kind = KIND_IGNORED;
				end
				seq = base_seq;
			end
			default: begin
				// timer tick: expiry rewinds next to base and stops the timer
				if (timer_on) begin
					limit = (timeout_reg == 0) ? 1 : 32'(timeout_reg);
					tick_count = tick_count + 16'd1;
					if (tick_count >= limit) begin
						next_seq = base_seq;
						timer_on = 1'b0;
						tick_count = '0;
						kind = KIND_REWIND;
					end
				end
			end
		endcase
		inflight = 32'(dist16(next_seq, base_seq));
		res.result_kind = kind;
		res.seq_number = seq;
		res.packet_out = word;
		res.outstanding = inflight[6:0];
		res.window_blocked = (next_seq == tail_seq || inflight >= win);
	endtask

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_seq = '0;
			next_seq = '0;
			tail_seq = '0;
			tick_count = '0;
			timer_on = 1'b0;
			base_slot = 0;
			win_reg = WINDOW_RESET;
			timeout_reg = TIMEOUT_RESET;
			event_result_q.delete();
			waiting <= 0;
			base_now <= '0;
			next_now <= '0;
		end else begin
			// compare a taken result item with the oldest prediction
			if (out_valid && !out_stall) begin
				if (event_result_q.size() == 0) begin
					report_mismatch("result with no event waiting, kind", '0,
						32'(out_item.result_kind));
				end else begin
					want = event_result_q[0];
					event_result_q.delete(0);
					if (out_item.result_kind !== want.result_kind) begin
						report_mismatch("result_kind", 32'(want.result_kind),
							32'(out_item.result_kind));
					end
					if (out_item.seq_number !== want.seq_number) begin
						report_mismatch("seq_number", 32'(want.seq_number),
							32'(out_item.seq_number));
					end
					if (out_item.packet_out !== want.packet_out) begin
						report_mismatch("packet_out", want.packet_out, out_item.packet_out);
					end
					if (out_item.outstanding !== want.outstanding) begin
						report_mismatch("outstanding", 32'(want.outstanding),
							32'(out_item.outstanding));
					end
					if (out_item.window_blocked !== want.window_blocked) begin
						report_mismatch("window_blocked", 32'(want.window_blocked),
							32'(out_item.window_blocked));
					end
				end
			end
			// predict each accepted event item
			if (in_valid && !in_stall) begin
				predict_window_event(in_item, fresh);
				event_result_q.push_back(fresh);
			end
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW:  win_reg = cfg_data[6:0];
					REG_TIMEOUT: timeout_reg = cfg_data;
					default:     ;
				endcase
			end
			waiting <= event_result_q.size();
			base_now <= base_seq;
			next_now <= next_seq;
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// testbench top for the go-back-n sender window: stimulus, register setup and verdict
module tb_top
	import gbn_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 6;
	localparam int MOOD_RUN = 25;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	reg_idx_t    cfg_index = REG_WINDOW;
	logic [15:0] cfg_data = '0;

	int          fail_count;
	int          waiting;
	logic [15:0] base_now;
	logic [15:0] next_now;
	int          src_idle = 13;
	int          dst_idle = 62;
	int          quiet = 0;
	in_item_t    opening [$];

	go_back_n_sender_window u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gbn_window_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.waiting   (waiting),
		.base_now  (base_now),
		.next_now  (next_now)
	);

	always #4 clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < dst_idle);
	end

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	function automatic in_item_t mk(input func_t f, input logic [31:0] word,
			input logic [15:0] ack);
		in_item_t it;
		it.func = f;
		it.packet_word = word;
		it.ack_number = ack;
		return it;
	endfunction

	// random event; mood 0 fills the buffer, 1 sends and acks, 2 leans on the timer
	function automatic in_item_t random_event(input int mood);
		in_item_t    it;
		int          pick;
		int          enq_top;
		int          send_top;
		int          ack_top;
		logic [15:0] span;
		it.packet_word = $urandom;
		it.ack_number = 16'($urandom);
		pick = $urandom_range(99);
		case (mood)
			0:       begin enq_top = 55; send_top = 80; ack_top = 90; end
			1:       begin enq_top = 15; send_top = 55; ack_top = 85; end
			default: begin enq_top = 20; send_top = 50; ack_top = 65; end
		endcase
		if (pick < enq_top) begin
			it.func = FUNC_ENQ;
		end else if (pick < send_top) begin
			it.func = FUNC_SEND;
		end else if (pick < ack_top) begin
			it.func = FUNC_ACK;
			span = next_now - base_now;
			// mostly acks of outstanding packets, the rest stale or out of range
			if (span != 0 && $urandom_range(9) < 8) begin
				it.ack_number = base_now + 16'($urandom_range(span - 1));
			end else begin
				case ($urandom_range(2))
					0:       ;
					1:       it.ack_number = base_now - 16'd1;
					default: it.ack_number = next_now;
				endcase
			end
		end else begin
			it.func = FUNC_TICK;
		end
		return it;
	endfunction

	// offer one event item, with random gaps before it, until it is taken
	task automatic put_item(input in_item_t it);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off until every predicted result has come out and the drain margin has passed
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [6:0] win, input logic [15:0] ticks);
		cfg_we <= 1'b1;
		cfg_index <= REG_WINDOW;
		cfg_data <= {9'd0, win};
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int src, input int dst, input int count,
			input logic [6:0] win, input logic [15:0] ticks);
		int mood;
		wait_for_drain();
		configure(win, ticks);
		src_idle = src;
		dst_idle <= dst;
		mood = 0;
		for (int i = 0; i < count; i++) begin
			if (i % MOOD_RUN == 0) begin
				mood = $urandom_range(2);
			end
			put_item(random_event(mood));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero window and zero timeout both act as one
		configure(7'd0, 16'd0);
		opening.push_back(mk(FUNC_TICK, 32'h0000_0000, 16'h0000)); // timer stopped
		opening.push_back(mk(FUNC_SEND, 32'hFFFF_FFFF, 16'hFFFF)); // nothing queued
		opening.push_back(mk(FUNC_ACK,  32'h0000_0000, 16'hFFFF)); // nothing outstanding
		opening.push_back(mk(FUNC_ENQ,  32'h0000_0000, 16'h0000));
		opening.push_back(mk(FUNC_ENQ,  32'hFFFF_FFFF, 16'hFFFF));
		opening.push_back(mk(FUNC_SEND, 32'h0000_0000, 16'h0000)); // base starts timer
		opening.push_back(mk(FUNC_SEND, 32'h0000_0000, 16'h0000)); // window full
		opening.push_back(mk(FUNC_ACK,  32'h0000_0000, 16'h0001)); // unsent packet
		opening.push_back(mk(FUNC_TICK, 32'h0000_0000, 16'h0000)); // expiry rewinds
		opening.push_back(mk(FUNC_TICK, 32'h0000_0000, 16'h0000)); // stopped again
		opening.push_back(mk(FUNC_SEND, 32'h0000_0000, 16'h0000)); // resend base
		opening.push_back(mk(FUNC_ACK,  32'hFFFF_FFFF, 16'h0000)); // all acked, timer off
		opening.push_back(mk(FUNC_ACK,  32'h0000_0000, 16'h0000)); // duplicate
		opening.push_back(mk(FUNC_SEND, 32'h0000_0000, 16'h0000));
		opening.push_back(mk(FUNC_ACK,  32'h0000_0000, 16'h0001));
		opening.push_back(mk(FUNC_ENQ,  32'hA5A5_5A5A, 16'h5A5A));
		opening.push_back(mk(FUNC_SEND, 32'h0000_0000, 16'h0000));
		opening.push_back(mk(FUNC_ACK,  32'h0000_0000, 16'hFFFF)); // far outside window
		foreach (opening[i]) begin
			put_item(opening[i]);
		end

		// sender rarely idle, receiver often stalled
		run_phase(13, 62, 250, 7'd127, 16'($urandom_range(2, 12)));
		// the other way round, window of one and the longest timeout
		run_phase(62, 13, 250, 7'd1, 16'hFFFF);
		// no idling on either side
		run_phase(0, 0, 125, 7'd64, 16'd1);
		run_phase(0, 0, 125, 7'($urandom_range(2, 63)), 16'($urandom_range(1, 16)));
		wait_for_drain();

		if (fail_count == 0 && waiting == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// File: go_back_n_sender_window.f
sv/gbn_pkg.sv
sv/gbn_ram.sv
sv/gbn_core.sv
sv/go_back_n_sender_window.sv
tb/sv/gbn_window_checker.sv
tb/sv/tb_top.sv
